### hw/rtl/integer_to_ascii_formatter_core_assert.svh
// Assertion macros for the integer-to-ASCII formatter core.
// Clocked on clk_i, disabled while rst_ni is low; no other dependencies.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/itoa_fmt_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies.
`default_nettype none

package itoa_fmt_pkg;

  localparam int INT_BITS_DEF = 32;
  localparam int PTR_BITS_DEF = 64;
  localparam int QUEUE_DEPTH  = 2;

  localparam int PRE_CHARS = 5;
  localparam int PRE_W     = PRE_CHARS * 8;
  localparam int PLEN_W    = 3;

  localparam logic [2:0] OP_LIT = 3'd0;
  localparam logic [2:0] OP_SDEC = 3'd1;
  localparam logic [2:0] OP_UDEC = 3'd2;
  localparam logic [2:0] OP_HEXL = 3'd3;
  localparam logic [2:0] OP_HEXU = 3'd4;
  localparam logic [2:0] OP_PTR = 3'd5;
  localparam logic [2:0] OP_UNK = 3'd6;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [PRE_W-1:0] NIL_STR = "(nil)";
  localparam logic [15:0] HEX_PFX = "0x";

  typedef struct packed {
    logic [PRE_W-1:0]  pre;
    logic [PLEN_W-1:0] pre_len;
    logic              has_num;
    logic              is_dec;
    logic              upper;
  } ctl_t;

  typedef struct packed {
    logic idle;
    logic emit_last;
  } bk_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return base + {4'd0, d} - 8'd10;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/itoa_fmt_front.sv
// Front end: classify one request into prefix characters and a magnitude.
// Depends on itoa_fmt_pkg.
`default_nettype none

module itoa_fmt_front #(
  parameter int INT_BITS = itoa_fmt_pkg::INT_BITS_DEF,
  parameter int PTR_BITS = itoa_fmt_pkg::PTR_BITS_DEF,
  parameter int MAG_W    = 64
) (
  input  wire logic [2:0]       opcode_i,
  input  wire logic [63:0]      value_i,
  output itoa_fmt_pkg::ctl_t    ctl_o,
  output logic [MAG_W-1:0]      mag_o,
  output logic                  keep_o
);

  localparam int PW = itoa_fmt_pkg::PRE_W;

  logic [INT_BITS-1:0] ival;
  logic [INT_BITS-1:0] ineg;
  logic [PTR_BITS-1:0] pval;

  assign ival = value_i[INT_BITS-1:0];
  assign ineg = -ival;
  assign pval = value_i[PTR_BITS-1:0];

  always_comb begin
    ctl_o   = '0;
    mag_o   = '0;
    keep_o  = 1'b1;
    case (opcode_i)
      itoa_fmt_pkg::OP_LIT: begin
        ctl_o.pre     = {value_i[7:0], {(PW-8){1'b0}}};
        ctl_o.pre_len = 3'd1;
      end
      itoa_fmt_pkg::OP_SDEC: begin
        ctl_o.has_num = 1'b1;
        ctl_o.is_dec  = 1'b1;
        if (ival[INT_BITS-1]) begin
          ctl_o.pre     = {itoa_fmt_pkg::CH_MINUS, {(PW-8){1'b0}}};
          ctl_o.pre_len = 3'd1;
          mag_o         = MAG_W'(ineg);
        end else begin
          mag_o = MAG_W'(ival);
        end
      end
      itoa_fmt_pkg::OP_UDEC: begin
        ctl_o.has_num = 1'b1;
        ctl_o.is_dec  = 1'b1;
        mag_o         = MAG_W'(ival);
      end
      itoa_fmt_pkg::OP_HEXL: begin
        ctl_o.has_num = 1'b1;
        mag_o         = MAG_W'(ival);
      end
      itoa_fmt_pkg::OP_HEXU: begin
        ctl_o.has_num = 1'b1;
        ctl_o.upper   = 1'b1;
        mag_o         = MAG_W'(ival);
      end
      itoa_fmt_pkg::OP_PTR: begin
        if (pval == '0) begin
          ctl_o.pre     = itoa_fmt_pkg::NIL_STR;
          ctl_o.pre_len = 3'd5;
        end else begin
          ctl_o.pre     = {itoa_fmt_pkg::HEX_PFX, {(PW-16){1'b0}}};
          ctl_o.pre_len = 3'd2;
          ctl_o.has_num = 1'b1;
          mag_o         = MAG_W'(pval);
        end
      end
      itoa_fmt_pkg::OP_UNK: begin
        ctl_o.pre     = {itoa_fmt_pkg::CH_PCT, value_i[7:0], {(PW-16){1'b0}}};
        ctl_o.pre_len = 3'd2;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/itoa_fmt_queue.sv
// Short FIFO between front and back: control word plus magnitude.
// Depends on itoa_fmt_pkg.
`default_nettype none

module itoa_fmt_queue #(
  parameter int MAG_W = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire itoa_fmt_pkg::ctl_t ctl_i,
  input  wire logic [MAG_W-1:0]   mag_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output itoa_fmt_pkg::ctl_t      ctl_o,
  output logic [MAG_W-1:0]        mag_o
);

  localparam int DEPTH = itoa_fmt_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  itoa_fmt_pkg::ctl_t ctl_q [DEPTH];
  logic [MAG_W-1:0]   mag_q [DEPTH];
  logic [PW-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign ctl_o   = ctl_q[rp_q];
  assign mag_o   = mag_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_q[wp_q] <= ctl_i;
      mag_q[wp_q] <= mag_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/itoa_fmt_back.sv
// Back end: decimal conversion (four bits per cycle), prefix and digit
// emission with leading-zero skip, output register. Depends on itoa_fmt_pkg.
`default_nettype none

module itoa_fmt_back #(
  parameter int INT_BITS = itoa_fmt_pkg::INT_BITS_DEF,
  parameter int MAG_W    = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire itoa_fmt_pkg::ctl_t q_ctl_i,
  input  wire logic [MAG_W-1:0]   q_mag_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              character_o,
  output logic                    last_char_o,
  output itoa_fmt_pkg::bk_stat_t  stat_o
);

  localparam int INT_NIB = (INT_BITS + 3) / 4;
  localparam int IW      = INT_NIB * 4;
  localparam int NIB     = (MAG_W + 3) / 4;
  localparam int DEC_DIG = (INT_BITS * 1233) / 4096 + 1;
  localparam int BW      = DEC_DIG * 4;
  localparam int DW      = (DEC_DIG > NIB) ? DEC_DIG : NIB;
  localparam int DGW     = DW * 4;
  localparam int CW      = $clog2(DW + 1);
  localparam int SCW     = $clog2(INT_NIB + 1);
  localparam int HEX_SH  = (DW - NIB) * 4;
  localparam int DEC_SH  = (DW - DEC_DIG) * 4;
  localparam int PW      = itoa_fmt_pkg::PRE_W;
  localparam int LW      = itoa_fmt_pkg::PLEN_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CONV   = 4'b0010,
    S_PREFIX = 4'b0100,
    S_DIGITS = 4'b1000
  } bk_state_e;

  bk_state_e      st_q, st_d;
  logic [PW-1:0]  pre_q, pre_d;
  logic [LW-1:0]  pcnt_q, pcnt_d;
  logic           num_q, num_d;
  logic           upper_q, upper_d;
  logic           started_q, started_d;
  logic [IW-1:0]  bin_q, bin_d, bin_n;
  logic [BW-1:0]  bcd_q, bcd_d, bcd_n;
  logic [DGW-1:0] dig_q, dig_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SCW-1:0] scnt_q, scnt_d;
  logic           ov_q;
  logic [7:0]     och_q;
  logic           olast_q;

  logic           out_free;
  logic           emit;
  logic [7:0]     ech;
  logic           elast;
  logic [3:0]     nib;

  assign out_free    = !ov_q || out_ready_i;
  assign nib         = dig_q[DGW-1 -: 4];
  assign out_valid_o = ov_q;
  assign character_o = och_q;
  assign last_char_o = olast_q;
  assign stat_o.idle      = (st_q == S_IDLE);
  assign stat_o.emit_last = emit && elast;

  always_comb begin
    bcd_n = bcd_q;
    bin_n = bin_q;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < DEC_DIG; k++) begin
        if (bcd_n[k*4 +: 4] >= 4'd5) begin
          bcd_n[k*4 +: 4] = bcd_n[k*4 +: 4] + 4'd3;
        end
      end
      bcd_n = {bcd_n[BW-2:0], bin_n[IW-1]};
      bin_n = {bin_n[IW-2:0], 1'b0};
    end
  end

  always_comb begin
    st_d      = st_q;
    pre_d     = pre_q;
    pcnt_d    = pcnt_q;
    num_d     = num_q;
    upper_d   = upper_q;
    started_d = started_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    dig_d     = dig_q;
    cnt_d     = cnt_q;
    scnt_d    = scnt_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    ech       = '0;
    elast     = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          pre_d     = q_ctl_i.pre;
          pcnt_d    = q_ctl_i.pre_len;
          num_d     = q_ctl_i.has_num;
          upper_d   = q_ctl_i.upper;
          started_d = 1'b0;
          bin_d     = IW'(q_mag_i);
          bcd_d     = '0;
          scnt_d    = SCW'(INT_NIB);
          dig_d     = DGW'(q_mag_i) << HEX_SH;
          cnt_d     = q_ctl_i.is_dec ? CW'(DEC_DIG) : CW'(NIB);
          if (q_ctl_i.has_num && q_ctl_i.is_dec) begin
            st_d = S_CONV;
          end else if (q_ctl_i.pre_len != '0) begin
            st_d = S_PREFIX;
          end else begin
            st_d = S_DIGITS;
          end
        end
      end
      S_CONV: begin
        bin_d  = bin_n;
        bcd_d  = bcd_n;
        scnt_d = scnt_q - 1'b1;
        if (scnt_q == SCW'(1)) begin
          dig_d = DGW'(bcd_n) << DEC_SH;
          st_d  = (pcnt_q != '0) ? S_PREFIX : S_DIGITS;
        end
      end
      S_PREFIX: begin
        if (out_free) begin
          emit   = 1'b1;
          ech    = pre_q[PW-1 -: 8];
          elast  = (pcnt_q == LW'(1)) && !num_q;
          pre_d  = pre_q << 8;
          pcnt_d = pcnt_q - 1'b1;
          if (pcnt_q == LW'(1)) begin
            st_d = num_q ? S_DIGITS : S_IDLE;
          end
        end
      end
      S_DIGITS: begin
        if (nib == 4'd0 && !started_q && cnt_q != CW'(1)) begin
          dig_d = dig_q << 4;
          cnt_d = cnt_q - 1'b1;
        end else if (out_free) begin
          emit      = 1'b1;
          ech       = itoa_fmt_pkg::digit_char(nib, upper_q);
          elast     = (cnt_q == CW'(1));
          started_d = 1'b1;
          dig_d     = dig_q << 4;
          cnt_d     = cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            st_d = S_IDLE;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q     <= pre_d;
    pcnt_q    <= pcnt_d;
    num_q     <= num_d;
    upper_q   <= upper_d;
    started_q <= started_d;
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    dig_q     <= dig_d;
    cnt_q     <= cnt_d;
    scnt_q    <= scnt_d;
    if (emit) begin
      och_q   <= ech;
      olast_q <= elast;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/integer_to_ascii_formatter_core.sv
// With the back end idle, an accepted item is written to the queue, popped by the
// sequencer in its idle state, and its first prefix character is then registered;
// decimal items first pass through the conversion state, and numbers also skip
// leading zeros. Prefix and digits leave at one character per cycle while the
// output is not stalled; the back end takes the next item only once it is idle.
// Reset clears the queue and the sequencer.
`default_nettype none

`include "integer_to_ascii_formatter_core_assert.svh"

module integer_to_ascii_formatter_core #(
  parameter int INT_BITS     = itoa_fmt_pkg::INT_BITS_DEF,
  parameter int POINTER_BITS = itoa_fmt_pkg::PTR_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       character_o,
  output logic             last_char_o
);

  localparam int MAG_W = (INT_BITS > POINTER_BITS) ? INT_BITS : POINTER_BITS;

  itoa_fmt_pkg::ctl_t     f_ctl, q_ctl;
  logic [MAG_W-1:0]       f_mag, q_mag;
  logic                   f_keep;
  logic                   q_full, q_valid, q_push, q_pop;
  itoa_fmt_pkg::bk_stat_t bk_stat;

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && in_ready_o && f_keep;

  itoa_fmt_front #(
    .INT_BITS (INT_BITS),
    .PTR_BITS (POINTER_BITS),
    .MAG_W    (MAG_W)
  ) u_front (
    .opcode_i (opcode_i),
    .value_i  (value_i),
    .ctl_o    (f_ctl),
    .mag_o    (f_mag),
    .keep_o   (f_keep)
  );

  itoa_fmt_queue #(
    .MAG_W (MAG_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ctl_i   (f_ctl),
    .mag_i   (f_mag),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .ctl_o   (q_ctl),
    .mag_o   (q_mag)
  );

  itoa_fmt_back #(
    .INT_BITS (INT_BITS),
    .MAG_W    (MAG_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ctl_i     (q_ctl),
    .q_mag_i     (q_mag),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_char_o (last_char_o),
    .stat_o      (bk_stat)
  );

  `ITOA_ASSERT_NOW(a_pop_when_idle, q_pop, bk_stat.idle && q_valid, "pop outside idle")
  `ITOA_ASSERT_NOW(a_push_has_room, q_push, !q_full, "push into full queue")
  `ITOA_ASSERT_NEXT(a_last_to_idle, bk_stat.emit_last,
                    bk_stat.idle && out_valid_o && last_char_o, "last char not followed by idle")

endmodule

`default_nettype wire
